[hw/rtl/fr_pkg.sv]
package fr_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned DEN_BITS    = 16;
  localparam int unsigned IN_WIDTH    = 48;
  localparam int unsigned WHOLE_WIDTH = 32;
  localparam int unsigned PROD_WIDTH  = FRAC_BITS + DEN_BITS;
  localparam int unsigned SHIFT_WIDTH = $clog2(DEN_BITS);

  localparam logic [DEN_BITS-1:0] DEN_RESET = DEN_BITS'(64);

  typedef struct packed {
    logic load;
    logic mult;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic gcd_done;
  } sts_t;

endpackage

[hw/rtl/fr_in_if.sv]
interface fr_in_if;
  import fr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] value_fixed;

  modport source (output valid, output value_fixed, input ready);
  modport sink (input valid, input value_fixed, output ready);
endinterface

[hw/rtl/fr_out_if.sv]
interface fr_out_if;
  import fr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [WHOLE_WIDTH-1:0] whole_part;
  logic        [DEN_BITS-1:0]    frac_numerator;
  logic        [DEN_BITS-1:0]    frac_denominator;

  modport source (output valid, output whole_part, output frac_numerator,
                  output frac_denominator, input ready);
  modport sink (input valid, input whole_part, input frac_numerator,
                input frac_denominator, output ready);
endinterface

[hw/rtl/fr_cfg_if.sv]
interface fr_cfg_if;
  import fr_pkg::*;

  logic                valid;
  logic                ready;
  logic [DEN_BITS-1:0] max_denominator;

  modport source (output valid, output max_denominator, input ready);
  modport sink (input valid, input max_denominator, output ready);
endinterface

[hw/rtl/fr_ctrl.sv]
module fr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  fr_pkg::sts_t  sts_i,
  output fr_pkg::cmd_t  cmd_o
);
  import fr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_GCD  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  localparam logic [SHIFT_WIDTH-1:0] CNT_LAST = SHIFT_WIDTH'(DEN_BITS - 1);

  state_e                 state_q, state_d;
  logic [SHIFT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mult = 1'b1;
        state_d    = S_GCD;
      end
      S_GCD: begin
        if (sts_i.n_zero) begin
          state_d = S_FIN;
        end else if (sts_i.gcd_done) begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = S_DIV;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && (cnt_q == CNT_LAST) |=> (state_q == S_FIN))
    else $error("divide did not end after its last step");

endmodule

[hw/rtl/fr_dp.sv]
module fr_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [fr_pkg::IN_WIDTH-1:0]        in_value_i,
  input  logic                               cfg_valid_i,
  input  logic [fr_pkg::DEN_BITS-1:0]        cfg_data_i,
  input  fr_pkg::cmd_t                       cmd_i,
  output fr_pkg::sts_t                       sts_o,
  output logic [fr_pkg::WHOLE_WIDTH-1:0]     whole_o,
  output logic [fr_pkg::DEN_BITS-1:0]        num_o,
  output logic [fr_pkg::DEN_BITS-1:0]        den_o
);
  import fr_pkg::*;

  logic [DEN_BITS-1:0]    max_den_q;
  logic [IN_WIDTH-1:0]    mag_q;
  logic                   neg_q;
  logic [WHOLE_WIDTH-1:0] whole_q;
  logic [DEN_BITS-1:0]    n_q;
  logic [DEN_BITS-1:0]    a_q, b_q;
  logic [SHIFT_WIDTH-1:0] k_q;
  logic [DEN_BITS-1:0]    g_q;
  logic [DEN_BITS-1:0]    qn_q, qd_q, rn_q, rd_q;
  logic [WHOLE_WIDTH-1:0] out_whole_q;
  logic [DEN_BITS-1:0]    out_num_q, out_den_q;

  logic [IN_WIDTH-1:0]    mag_d;
  logic [IN_WIDTH-1:0]    whole_mag;
  logic [IN_WIDTH-1:0]    whole_sgn;
  logic [PROD_WIDTH-1:0]  prod;
  logic [DEN_BITS-1:0]    n_d;
  logic [DEN_BITS-1:0]    a_d, b_d;
  logic [SHIFT_WIDTH-1:0] k_d;
  logic [DEN_BITS:0]      rn_ext, rd_ext, rn_sub, rd_sub;

  assign mag_d     = in_value_i[IN_WIDTH-1] ? (~in_value_i + 1'b1) : in_value_i;
  assign whole_mag = mag_q >> FRAC_BITS;
  assign whole_sgn = neg_q ? (~whole_mag + 1'b1) : whole_mag;
  assign prod      = PROD_WIDTH'(mag_q[FRAC_BITS-1:0]) * PROD_WIDTH'(max_den_q);
  assign n_d       = prod[PROD_WIDTH-1:FRAC_BITS] + DEN_BITS'(prod[FRAC_BITS-1]);

  assign sts_o.n_zero   = (n_q == '0);
  assign sts_o.gcd_done = (a_q == b_q);

  // binary gcd: strip shared twos, halve a lone even operand, else shrink the larger odd one
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (!a_q[0] && !b_q[0]) begin
      a_d = a_q >> 1;
      b_d = b_q >> 1;
      k_d = k_q + 1'b1;
    end else if (!a_q[0]) begin
      a_d = a_q >> 1;
    end else if (!b_q[0]) begin
      b_d = b_q >> 1;
    end else if (a_q > b_q) begin
      a_d = (a_q - b_q) >> 1;
    end else begin
      b_d = (b_q - a_q) >> 1;
    end
  end

  assign rn_ext = {rn_q, qn_q[DEN_BITS-1]};
  assign rd_ext = {rd_q, qd_q[DEN_BITS-1]};
  assign rn_sub = rn_ext - {1'b0, g_q};
  assign rd_sub = rd_ext - {1'b0, g_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_den_q <= DEN_RESET;
    end else if (cfg_valid_i) begin
      max_den_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= mag_d;
      neg_q <= in_value_i[IN_WIDTH-1];
    end
    if (cmd_i.mult) begin
      whole_q <= whole_sgn[WHOLE_WIDTH-1:0];
      n_q     <= n_d;
      a_q     <= n_d;
      b_q     <= max_den_q;
      k_q     <= '0;
    end else if (cmd_i.gcd_step) begin
      a_q <= a_d;
      b_q <= b_d;
      k_q <= k_d;
    end
    if (cmd_i.div_init) begin
      g_q  <= a_q << k_q;
      qn_q <= n_q;
      qd_q <= max_den_q;
      rn_q <= '0;
      rd_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!rn_sub[DEN_BITS]) begin
        rn_q <= rn_sub[DEN_BITS-1:0];
        qn_q <= {qn_q[DEN_BITS-2:0], 1'b1};
      end else begin
        rn_q <= rn_ext[DEN_BITS-1:0];
        qn_q <= {qn_q[DEN_BITS-2:0], 1'b0};
      end
      if (!rd_sub[DEN_BITS]) begin
        rd_q <= rd_sub[DEN_BITS-1:0];
        qd_q <= {qd_q[DEN_BITS-2:0], 1'b1};
      end else begin
        rd_q <= rd_ext[DEN_BITS-1:0];
        qd_q <= {qd_q[DEN_BITS-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      out_whole_q <= whole_q;
      if (sts_o.n_zero) begin
        out_num_q <= '0;
        out_den_q <= DEN_BITS'(1);
      end else begin
        out_num_q <= qn_q;
        out_den_q <= qd_q;
      end
    end
  end

  assign whole_o = out_whole_q;
  assign num_o   = out_num_q;
  assign den_o   = out_den_q;

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gcd_step |=> (a_q != '0) && (b_q != '0))
    else $error("gcd operand reached zero");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (g_q != '0))
    else $error("divide by zero gcd");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (out_den_q != '0) && (out_num_q <= out_den_q))
    else $error("bad reduced fraction");

endmodule

[hw/rtl/fraction_reducer.sv]
// Sequence: load and multiply; a fraction that rounds to zero goes straight to the
//   result, else binary gcd steps (at most 2*DEN_BITS) and the divider run first.
// Throughput: one item at a time; the next input beat is taken the cycle after
//   the result is loaded, set by the gcd loop and the DEN_BITS-step divider.
// Reset: asynchronous, active low; clears control and sets max_denominator to 64.
module fraction_reducer (
  input  logic   clk_i,
  input  logic   rst_ni,
  fr_in_if.sink  in_i,
  fr_cfg_if.sink cfg_i,
  fr_out_if.source out_o
);
  import fr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [WHOLE_WIDTH-1:0] whole;

  assign cfg_i.ready = 1'b1;

  fr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_value_i  (in_i.value_fixed),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.max_denominator),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .whole_o     (whole),
    .num_o       (out_o.frac_numerator),
    .den_o       (out_o.frac_denominator)
  );

  assign out_o.whole_part = whole;

endmodule

[verif/tb_fraction_reducer.sv]
module tb_fraction_reducer;
  import fr_pkg::*;

  localparam int unsigned STALL_LIMIT      = 4000;
  localparam int unsigned DRAIN_CYCLES     = 60;
  localparam int unsigned RANDOM_PER_PHASE = 68;
  localparam int unsigned REPORT_CAP       = 100;

  typedef enum int unsigned {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic signed [WHOLE_WIDTH-1:0] whole;
    logic        [DEN_BITS-1:0]    num;
    logic        [DEN_BITS-1:0]    den;
  } fraction_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fr_in_if  in_if ();
  fr_cfg_if cfg_if ();
  fr_out_if out_if ();

  fraction_reducer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  logic signed [IN_WIDTH-1:0] value_q[$];
  fraction_t                  fraction_q[$];
  logic [DEN_BITS-1:0]        max_den_model;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_values       = 0;
  int unsigned n_fractions    = 0;
  int unsigned n_errors       = 0;
  int unsigned n_writes       = 0;
  int unsigned idle_cycles    = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic fraction_t reduce_fraction(input logic signed [IN_WIDTH-1:0] v,
                                                input logic [DEN_BITS-1:0] md);
    logic                        neg;
    logic [IN_WIDTH:0]           mag;
    logic [IN_WIDTH-FRAC_BITS:0] wm;
    logic [IN_WIDTH-FRAC_BITS:0] w;
    logic [FRAC_BITS-1:0]        f;
    logic [PROD_WIDTH-1:0]       prod;
    logic [DEN_BITS:0]           n;
    logic [DEN_BITS:0]           a;
    logic [DEN_BITS:0]           b;
    logic [DEN_BITS:0]           r;
    fraction_t                   res;
    neg  = v[IN_WIDTH-1];
    mag  = neg ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
    wm   = mag[IN_WIDTH:FRAC_BITS];
    w    = neg ? -wm : wm;
    f    = mag[FRAC_BITS-1:0];
    res.whole = w[WHOLE_WIDTH-1:0];
    res.num   = '0;
    res.den   = DEN_BITS'(1);
    if (f != '0 && md != '0) begin
      prod = f * md;
      n    = prod[PROD_WIDTH-1:FRAC_BITS] + prod[FRAC_BITS-1];
      if (n != '0) begin
        a = n;
        b = {1'b0, md};
        while (b != '0) begin
          r = a % b;
          a = b;
          b = r;
        end
        res.num = DEN_BITS'(n / a);
        res.den = DEN_BITS'({1'b0, md} / a);
      end
    end
    return res;
  endfunction

  function automatic logic signed [IN_WIDTH-1:0] make_value(input logic [DEN_BITS-1:0] md);
    logic [WHOLE_WIDTH-2:0] whole_mag;
    logic [FRAC_BITS-1:0]   f;
    logic [IN_WIDTH-1:0]    v;
    longint                 k;
    longint                 t;
    whole_mag = (WHOLE_WIDTH-1)'($urandom_range(40));
    f         = FRAC_BITS'($urandom);
    case ($urandom_range(9))
      0, 1, 2: return IN_WIDTH'({$urandom, $urandom});
      7: begin
        f         = '0;
        whole_mag = (WHOLE_WIDTH-1)'($urandom);
      end
      8: begin
        if ($urandom_range(1)) f = FRAC_BITS'($urandom_range(1, 3));
        else f = ~FRAC_BITS'($urandom_range(2));
      end
      9: whole_mag = ~(WHOLE_WIDTH-1)'($urandom_range(3));
      default: begin
        if (md != '0) begin
          k = longint'($urandom_range(md));
          t = (k << FRAC_BITS) / longint'(md);
          t = t + longint'($urandom_range(2)) - 1;
          if (t < 0) t = 0;
          if (t > (1 << FRAC_BITS) - 1) t = (1 << FRAC_BITS) - 1;
          f = FRAC_BITS'(t);
        end
      end
    endcase
    v = {1'b0, whole_mag, f};
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    if (n_errors < REPORT_CAP) $display("MISMATCH at %0t: %s", $time, what);
    n_errors++;
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_gap_pct = 86; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_gap_pct = 0;  recv_stall_pct = 86; end
      default:   begin send_gap_pct = 25; recv_stall_pct = 25; end
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (value_q.size() != 0 || in_if.valid || fraction_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_den(input logic [DEN_BITS-1:0] v);
    @(posedge clk_i);
    cfg_if.valid           <= 1'b1;
    cfg_if.max_denominator <= v;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.value_fixed <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (value_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        in_if.valid       <= 1'b1;
        in_if.value_fixed <= value_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    fraction_t want;
    if (!rst_ni) begin
      out_if.ready  <= 1'b0;
      max_den_model = DEN_RESET;
      idle_cycles   = 0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (cfg_if.valid && cfg_if.ready) begin
        max_den_model = cfg_if.max_denominator;
        n_writes++;
      end
      if (in_if.valid && in_if.ready) begin
        fraction_q.push_back(reduce_fraction(in_if.value_fixed, max_den_model));
        n_values++;
      end
      if (out_if.valid && out_if.ready) begin
        if (fraction_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat: whole %0d frac %0d/%0d",
                                    out_if.whole_part, out_if.frac_numerator,
                                    out_if.frac_denominator));
        end else begin
          want = fraction_q.pop_front();
          if (out_if.whole_part !== want.whole)
            report_mismatch($sformatf("whole_part %0d, want %0d",
                                      out_if.whole_part, want.whole));
          if (out_if.frac_numerator !== want.num)
            report_mismatch($sformatf("frac_numerator %0d, want %0d",
                                      out_if.frac_numerator, want.num));
          if (out_if.frac_denominator !== want.den)
            report_mismatch($sformatf("frac_denominator %0d, want %0d",
                                      out_if.frac_denominator, want.den));
          n_fractions++;
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                   idle_cycles, fraction_q.size());
          $display("tb_fraction_reducer NOT OK");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [DEN_BITS-1:0] den_plan[$];
    logic [DEN_BITS-1:0] md;
    cfg_if.valid           = 1'b0;
    cfg_if.max_denominator = '0;
    den_plan = '{16'd1, 16'd65535, 16'd0, 16'd2, 16'd3, 16'd7, 16'd10, 16'd60,
                 16'd100, 16'd360, 16'd1000, 16'd4096, 16'd32768, 16'd65521, 16'd12345};
    repeat (3) den_plan.push_back(DEN_BITS'($urandom_range(1, 65535)));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_idling(IDLE_NONE);
    @(negedge clk_i);
    value_q.push_back(48'sh0000_0000_0000);
    value_q.push_back(48'sh0000_0000_0001);
    value_q.push_back(-48'sh0000_0000_0001);
    value_q.push_back(48'sh7FFF_FFFF_FFFF);
    value_q.push_back(48'sh8000_0000_0000);
    value_q.push_back(48'sh8000_0000_0001);
    value_q.push_back(48'sh7FFF_FFFF_0000);
    value_q.push_back(48'sh8000_0000_FFFF);
    value_q.push_back(48'sh0000_0005_0000);
    value_q.push_back(-48'sh0000_0005_0000);
    value_q.push_back(48'sh0000_0000_8000);
    value_q.push_back(-48'sh0000_0001_8000);
    value_q.push_back(48'sh0000_0000_FFFF);
    value_q.push_back(-48'sh0000_0000_FFFF);
    value_q.push_back(48'sh0000_0000_0100);
    value_q.push_back(48'sh0000_0000_0200);
    value_q.push_back(48'sh0000_0000_0400);
    value_q.push_back(48'sh0000_0003_C000);
    value_q.push_back(48'sh0000_0000_5555);
    value_q.push_back(48'sh0000_7FFF_8000);
    value_q.push_back(48'shFFFF_FFFF_8000);

    foreach (den_plan[p]) begin
      md = den_plan[p];
      wait_drained();
      write_max_den(md);
      set_idling(idle_mode_e'((p + 1) % 4));
      @(negedge clk_i);
      repeat (RANDOM_PER_PHASE) value_q.push_back(make_value(md));
    end

    wait_drained();
    if (fraction_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", fraction_q.size()));
    $display("covered %0d values and %0d results over %0d max_denominator writes",
             n_values, n_fractions, n_writes);
    $display("denominators 0, 1 and 65535 included; idle, gap, stall and mixed phases");
    if (n_errors == 0) begin
      $display("tb_fraction_reducer OK");
    end else begin
      $display("tb_fraction_reducer NOT OK");
    end
    $finish;
  end

endmodule
